[hdl/qnlerp_pkg.sv]
// ----------------------------------------------------------------------------
// qnlerp_pkg
// Shared widths, constants and types of the quaternion nlerp datapath.
// ----------------------------------------------------------------------------
package qnlerp_pkg;

  localparam int CW       = 16;  // input component width
  localparam int FW       = 15;  // blend factor width
  localparam int VW       = 17;  // interpolated component width
  localparam int SQW      = 32;  // one squared component
  localparam int L2W      = 33;  // sum of four squares
  localparam int LSH      = 16;  // pre-shift of the squared length
  localparam int NW       = L2W + LSH;  // sqrt radicand width
  localparam int SRW      = NW + 1;     // sqrt remainder width
  localparam int LENW     = 25;         // length width, Q.22
  localparam int QW       = 16;         // quotient bits
  localparam int OSH      = 22;         // output scale shift
  localparam int DIVW     = 40;         // divider remainder width
  localparam int FRAC     = 14;
  localparam int ONE_Q14  = 16384;
  localparam int HALF_Q14 = 8192;

  typedef logic signed [CW-1:0] comp_t;
  typedef logic signed [VW-1:0] vcomp_t;
  typedef logic [LENW-1:0]      len_t;

endpackage

[hdl/quaternion_nlerp_normalize.sv]
// ----------------------------------------------------------------------------
// quaternion_nlerp_normalize
// Fixed-point normalized linear interpolation of two quaternions.
// ----------------------------------------------------------------------------
// usage
//   input channel: in_valid / in_ready carry one transaction holding the
//   source and destination quaternions (Q1.14), the blend factor and the
//   shortest-path flag
//   output channel: out_valid / out_ready carry one transaction per input,
//   the unit quaternion in Q1.14 plus out_zero_length
//   pipeline: 5 blend stages, 25 square-root stages, 18 divider stages
//   throughput: one transaction per cycle while out_ready stays high, set by
//   the fully pipelined sqrt and divider that resolve one bit per stage
//   reset: rst_n clears every stage valid bit, the pipe comes up empty
//   stall: when out_ready is low the last stage holds, and each earlier
//   stage keeps moving until it meets a full stage, so bubbles close up and
//   nothing is lost or repeated
// ----------------------------------------------------------------------------
module quaternion_nlerp_normalize import qnlerp_pkg::*; (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  comp_t          in_src_x,
  input  comp_t          in_src_y,
  input  comp_t          in_src_z,
  input  comp_t          in_src_w,
  input  comp_t          in_dest_x,
  input  comp_t          in_dest_y,
  input  comp_t          in_dest_z,
  input  comp_t          in_dest_w,
  input  logic [FW-1:0]  in_blend_factor,
  input  logic           in_take_shortest,
  output logic           out_valid,
  input  logic           out_ready,
  output comp_t          out_x,
  output comp_t          out_y,
  output comp_t          out_z,
  output comp_t          out_w,
  output logic           out_zero_length
);

  comp_t          src [4];
  comp_t          dest [4];
  // blend to sqrt
  logic           b_valid, b_ready;
  vcomp_t         b_v [4];
  logic [NW-1:0]  b_nsq;
  logic           b_zero;
  // sqrt to divider
  logic           s_valid, s_ready;
  len_t           s_len;
  vcomp_t         s_v [4];
  logic           s_zero;
  comp_t          q [4];

  assign src[0]  = in_src_x;
  assign src[1]  = in_src_y;
  assign src[2]  = in_src_z;
  assign src[3]  = in_src_w;
  assign dest[0] = in_dest_x;
  assign dest[1] = in_dest_y;
  assign dest[2] = in_dest_z;
  assign dest[3] = in_dest_w;

  // shortest-path select, blend and squared length
  qnlerp_blend u_blend (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .src       (src),
    .dest      (dest),
    .factor    (in_blend_factor),
    .shortest  (in_take_shortest),
    .out_valid (b_valid),
    .out_ready (b_ready),
    .v         (b_v),
    .nsq       (b_nsq),
    .zero      (b_zero)
  );

  // length in Q.22
  qnlerp_sqrt u_sqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (b_valid),
    .in_ready  (b_ready),
    .nsq       (b_nsq),
    .v_in      (b_v),
    .zero_in   (b_zero),
    .out_valid (s_valid),
    .out_ready (s_ready),
    .len       (s_len),
    .v_out     (s_v),
    .zero_out  (s_zero)
  );

  // per-component divide, round, saturate
  qnlerp_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (s_valid),
    .in_ready  (s_ready),
    .len       (s_len),
    .v         (s_v),
    .zero_in   (s_zero),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .q_out     (q),
    .zero_out  (out_zero_length)
  );

  assign out_x = q[0];
  assign out_y = q[1];
  assign out_z = q[2];
  assign out_w = q[3];

endmodule

[hdl/qnlerp_blend.sv]
// ----------------------------------------------------------------------------
// qnlerp_blend
// Shortest-path select, interpolation and squared length, five stages.
// ----------------------------------------------------------------------------
module qnlerp_blend import qnlerp_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  comp_t           src [4],
  input  comp_t           dest [4],
  input  logic [FW-1:0]   factor,
  input  logic            shortest,
  output logic            out_valid,
  input  logic            out_ready,
  output vcomp_t          v [4],
  output logic [NW-1:0]   nsq,
  output logic            zero
);

  localparam int NS = 5;

  logic [NS-1:0] vld_r;
  logic [NS-1:0] adv;

  // stage 1
  comp_t                 s1_s_r [4];
  comp_t                 s1_d_r [4];
  logic signed [31:0]    s1_p_r [4];
  logic [FW-1:0]         s1_f_r;
  logic                  s1_sh_r;
  // stage 2
  comp_t                 s2_s_r [4];
  logic signed [33:0]    s2_m_r [4];
  // stage 3
  vcomp_t                s3_v_r [4];
  // stage 4
  vcomp_t                s4_v_r [4];
  logic [SQW-1:0]        s4_q_r [4];
  // stage 5
  vcomp_t                s5_v_r [4];
  logic [NW-1:0]         s5_n_r;
  logic                  s5_z_r;

  logic [FW-1:0]         f_sat;
  logic signed [33:0]    dot;
  logic                  neg;
  logic signed [33:0]    m_nxt [4];
  vcomp_t                v_nxt [4];
  logic [SQW-1:0]        q_nxt [4];
  logic [L2W-1:0]        l2;

  always_comb begin
    adv[NS-1] = !vld_r[NS-1] || out_ready;
    for (int i = NS-2; i >= 0; i--) begin
      adv[i] = !vld_r[i] || adv[i+1];
    end
  end

  assign in_ready  = adv[0];
  assign out_valid = vld_r[NS-1];

  assign f_sat = (factor > FW'(ONE_Q14)) ? FW'(ONE_Q14) : factor;

  always_comb begin
    logic signed [16:0] dx;
    logic signed [17:0] diff;
    logic signed [34:0] r;
    logic signed [34:0] sum;
    logic signed [33:0] sq;
    dot = '0;
    for (int i = 0; i < 4; i++) begin
      dot = dot + 34'(s1_p_r[i]);
    end
    neg = s1_sh_r && dot[33];
    l2 = '0;
    for (int i = 0; i < 4; i++) begin
      dx = {s1_d_r[i][CW-1], s1_d_r[i]};
      if (neg) begin
        dx = -dx;
      end
      diff     = {dx[16], dx} - {{2{s1_s_r[i][CW-1]}}, s1_s_r[i]};
      m_nxt[i] = diff * $signed({1'b0, s1_f_r});
      r        = {s2_m_r[i][33], s2_m_r[i]} + 35'sd8192;
      sum      = (r >>> FRAC) + {{19{s2_s_r[i][CW-1]}}, s2_s_r[i]};
      v_nxt[i] = sum[VW-1:0];
      sq       = s3_v_r[i] * s3_v_r[i];
      q_nxt[i] = sq[SQW-1:0];
      l2       = l2 + L2W'(s4_q_r[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (adv[0]) vld_r[0] <= in_valid;
      for (int i = 1; i < NS; i++) begin
        if (adv[i]) vld_r[i] <= vld_r[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      for (int i = 0; i < 4; i++) begin
        s1_s_r[i] <= src[i];
        s1_d_r[i] <= dest[i];
        s1_p_r[i] <= src[i] * dest[i];
      end
      s1_f_r  <= f_sat;
      s1_sh_r <= shortest;
    end
    if (adv[1]) begin
      for (int i = 0; i < 4; i++) begin
        s2_s_r[i] <= s1_s_r[i];
        s2_m_r[i] <= m_nxt[i];
      end
    end
    if (adv[2]) begin
      for (int i = 0; i < 4; i++) s3_v_r[i] <= v_nxt[i];
    end
    if (adv[3]) begin
      for (int i = 0; i < 4; i++) begin
        s4_v_r[i] <= s3_v_r[i];
        s4_q_r[i] <= q_nxt[i];
      end
    end
    if (adv[4]) begin
      for (int i = 0; i < 4; i++) s5_v_r[i] <= s4_v_r[i];
      s5_n_r <= {l2, LSH'(0)};
      s5_z_r <= (l2 == '0);
    end
  end

  assign v    = s5_v_r;
  assign nsq  = s5_n_r;
  assign zero = s5_z_r;

endmodule

[hdl/qnlerp_sqrt.sv]
// ----------------------------------------------------------------------------
// qnlerp_sqrt
// Pipelined integer square root, one root bit per stage.
// ----------------------------------------------------------------------------
module qnlerp_sqrt import qnlerp_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic [NW-1:0]   nsq,
  input  vcomp_t          v_in [4],
  input  logic            zero_in,
  output logic            out_valid,
  input  logic            out_ready,
  output len_t            len,
  output vcomp_t          v_out [4],
  output logic            zero_out
);

  localparam int NS = LENW;

  logic [NS-1:0]   vld_r;
  logic [NS-1:0]   adv;
  logic [SRW-1:0]  rem_r  [NS];
  len_t            root_r [NS];
  vcomp_t          v_r    [NS][4];
  logic            zero_r [NS];
  logic [SRW-1:0]  rem_nxt  [NS];
  len_t            root_nxt [NS];

  always_comb begin
    adv[NS-1] = !vld_r[NS-1] || out_ready;
    for (int i = NS-2; i >= 0; i--) begin
      adv[i] = !vld_r[i] || adv[i+1];
    end
  end

  assign in_ready  = adv[0];
  assign out_valid = vld_r[NS-1];

  // stage j settles root bit LENW-1-j
  always_comb begin
    logic [SRW-1:0] rin;
    len_t           qin;
    logic [SRW-1:0] t;
    for (int j = 0; j < NS; j++) begin
      if (j == 0) begin
        rin = SRW'(nsq);
        qin = '0;
      end else begin
        rin = rem_r[j-1];
        qin = root_r[j-1];
      end
      t = (SRW'(qin) << (NS-j)) | (SRW'(1) << (2*(NS-1-j)));
      if (rin >= t) begin
        rem_nxt[j]  = rin - t;
        root_nxt[j] = qin | (len_t'(1) << (NS-1-j));
      end else begin
        rem_nxt[j]  = rin;
        root_nxt[j] = qin;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (adv[0]) vld_r[0] <= in_valid;
      for (int i = 1; i < NS; i++) begin
        if (adv[i]) vld_r[i] <= vld_r[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int j = 0; j < NS; j++) begin
      if (adv[j]) begin
        rem_r[j]  <= rem_nxt[j];
        root_r[j] <= root_nxt[j];
        if (j == 0) begin
          v_r[j]    <= v_in;
          zero_r[j] <= zero_in;
        end else begin
          v_r[j]    <= v_r[j-1];
          zero_r[j] <= zero_r[j-1];
        end
      end
    end
  end

  assign len      = root_r[NS-1];
  assign v_out    = v_r[NS-1];
  assign zero_out = zero_r[NS-1];

endmodule

[hdl/qnlerp_div.sv]
// ----------------------------------------------------------------------------
// qnlerp_div
// Four-lane pipelined restoring divider with rounding and saturation.
// ----------------------------------------------------------------------------
module qnlerp_div import qnlerp_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  len_t            len,
  input  vcomp_t          v [4],
  input  logic            zero_in,
  output logic            out_valid,
  input  logic            out_ready,
  output comp_t           q_out [4],
  output logic            zero_out
);

  localparam int NS = QW + 2;  // numerator stage, QW bit stages, output stage

  logic [NS-1:0]    vld_r;
  logic [NS-1:0]    adv;
  logic [DIVW-1:0]  rem_r  [QW+1][4];
  logic [QW-1:0]    quo_r  [QW+1][4];
  logic             sgn_r  [QW+1][4];
  len_t             len_r  [QW+1];
  logic             zero_r [QW+1];
  comp_t            out_r  [4];
  logic             zo_r;

  logic [DIVW-1:0]  rem_nxt [QW+1][4];
  logic [QW-1:0]    quo_nxt [QW+1][4];
  len_t             len0;
  comp_t            res_nxt [4];

  always_comb begin
    adv[NS-1] = !vld_r[NS-1] || out_ready;
    for (int i = NS-2; i >= 0; i--) begin
      adv[i] = !vld_r[i] || adv[i+1];
    end
  end

  assign in_ready  = adv[0];
  assign out_valid = vld_r[NS-1];

  assign len0 = (len == '0) ? len_t'(1) : len;

  always_comb begin
    logic [CW-1:0]   mag;
    logic [DIVW-1:0] dv;
    logic [QW-1:0]   qs;
    for (int i = 0; i < 4; i++) begin
      mag = v[i][VW-1] ? CW'(-v[i]) : CW'(v[i]);
      rem_nxt[0][i] = (DIVW'(mag) << OSH) + DIVW'(len0 >> 1);
      quo_nxt[0][i] = '0;
      for (int j = 1; j <= QW; j++) begin
        dv = DIVW'(len_r[j-1]) << (QW-j);
        if (rem_r[j-1][i] >= dv) begin
          rem_nxt[j][i] = rem_r[j-1][i] - dv;
          quo_nxt[j][i] = quo_r[j-1][i] | (QW'(1) << (QW-j));
        end else begin
          rem_nxt[j][i] = rem_r[j-1][i];
          quo_nxt[j][i] = quo_r[j-1][i];
        end
      end
      qs = (quo_r[QW][i] > QW'(ONE_Q14)) ? QW'(ONE_Q14) : quo_r[QW][i];
      if (zero_r[QW]) begin
        res_nxt[i] = '0;
      end else if (sgn_r[QW][i]) begin
        res_nxt[i] = -$signed(qs);
      end else begin
        res_nxt[i] = $signed(qs);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (adv[0]) vld_r[0] <= in_valid;
      for (int i = 1; i < NS; i++) begin
        if (adv[i]) vld_r[i] <= vld_r[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    // numerator stage
    if (adv[0]) begin
      for (int i = 0; i < 4; i++) begin
        rem_r[0][i] <= rem_nxt[0][i];
        quo_r[0][i] <= quo_nxt[0][i];
        sgn_r[0][i] <= v[i][VW-1];
      end
      len_r[0]  <= len0;
      zero_r[0] <= zero_in;
    end
    for (int j = 1; j <= QW; j++) begin
      if (adv[j]) begin
        for (int i = 0; i < 4; i++) begin
          rem_r[j][i] <= rem_nxt[j][i];
          quo_r[j][i] <= quo_nxt[j][i];
          sgn_r[j][i] <= sgn_r[j-1][i];
        end
        len_r[j]  <= len_r[j-1];
        zero_r[j] <= zero_r[j-1];
      end
    end
    if (adv[NS-1]) begin
      out_r <= res_nxt;
      zo_r  <= zero_r[QW];
    end
  end

  assign q_out    = out_r;
  assign zero_out = zo_r;

endmodule

[tb/nlerp_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nlerp_checker
// Watches both channels of the nlerp block, predicts each result from the
// accepted input transaction and compares the outputs field by field.
// ----------------------------------------------------------------------------
module nlerp_checker import qnlerp_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  logic          in_ready,
  input  comp_t         in_src_x,
  input  comp_t         in_src_y,
  input  comp_t         in_src_z,
  input  comp_t         in_src_w,
  input  comp_t         in_dest_x,
  input  comp_t         in_dest_y,
  input  comp_t         in_dest_z,
  input  comp_t         in_dest_w,
  input  logic [FW-1:0] in_blend_factor,
  input  logic          in_take_shortest,
  input  logic          out_valid,
  input  logic          out_ready,
  input  comp_t         out_x,
  input  comp_t         out_y,
  input  comp_t         out_z,
  input  comp_t         out_w,
  input  logic          out_zero_length,
  output int            fail_count,
  output int            pending
);

  typedef struct packed {
    comp_t x, y, z, w;
    logic  zl;
  } unit_quat_t;

  unit_quat_t expected_quats[$];

  function automatic unit_quat_t blend_and_normalize(
    input comp_t sx, sy, sz, sw, dx, dy, dz, dw,
    input logic [FW-1:0] fac, input logic shortest);
    longint s[4], d[4], v[4];
    longint dot, f, prod, fl, l2, rad, root, rem, bitv, mag, q;
    unit_quat_t r;
    comp_t o[4];
    s = '{sx, sy, sz, sw};
    d = '{dx, dy, dz, dw};
    dot = 0;
    for (int i = 0; i < 4; i++) dot += s[i] * d[i];
    f = fac;
    if (f > ONE_Q14) f = ONE_Q14;
    if (shortest && dot < 0)
      for (int i = 0; i < 4; i++) d[i] = -d[i];
    l2 = 0;
    for (int i = 0; i < 4; i++) begin
      prod = (d[i] - s[i]) * f + HALF_Q14;
      // floor division by 2^14
      fl = (prod >= 0) ? (prod >>> FRAC) : -((-prod + ONE_Q14 - 1) >>> FRAC);
      v[i] = s[i] + fl;
      l2 += v[i] * v[i];
    end
    if (l2 == 0) begin
      r = '{x: '0, y: '0, z: '0, w: '0, zl: 1'b1};
      return r;
    end
    // bitwise integer square root of l2 * 2^16 (fits in 50 bits)
    rad = l2 <<< LSH;
    root = 0;
    bitv = 64'sd1 <<< 60;
    while (bitv > rad) bitv = bitv >>> 2;
    rem = rad;
    while (bitv != 0) begin
      if (rem >= root + bitv) begin
        rem -= root + bitv;
        root = (root >>> 1) + bitv;
      end else begin
        root = root >>> 1;
      end
      bitv = bitv >>> 2;
    end
    if (root == 0) root = 1;
    for (int i = 0; i < 4; i++) begin
      mag = (v[i] < 0) ? -v[i] : v[i];
      q = ((mag <<< OSH) + (root >>> 1)) / root;
      if (q > ONE_Q14) q = ONE_Q14;
      o[i] = (v[i] < 0) ? comp_t'(-q) : comp_t'(q);
    end
    r = '{x: o[0], y: o[1], z: o[2], w: o[3], zl: 1'b0};
    return r;
  endfunction

  always @(posedge clk) begin
    unit_quat_t e;
    if (!rst_n) begin
      fail_count <= 0;
      pending    <= 0;
    end else begin
      if (in_valid && in_ready)
        expected_quats.push_back(blend_and_normalize(in_src_x, in_src_y, in_src_z,
          in_src_w, in_dest_x, in_dest_y, in_dest_z, in_dest_w, in_blend_factor,
          in_take_shortest));
      if (out_valid && out_ready) begin
        if (expected_quats.size() == 0) begin
          if (fail_count < 10) $display("unexpected result transaction");
          fail_count <= fail_count + 1;
        end else begin
          e = expected_quats.pop_front();
          if (e.x !== out_x || e.y !== out_y || e.z !== out_z || e.w !== out_w ||
              e.zl !== out_zero_length) begin
            if (fail_count < 10)
              $display("mismatch: exp %0d %0d %0d %0d zl=%0b got %0d %0d %0d %0d zl=%0b",
                e.x, e.y, e.z, e.w, e.zl, out_x, out_y, out_z, out_w, out_zero_length);
            fail_count <= fail_count + 1;
          end
        end
      end
      pending <= expected_quats.size();
    end
  end

endmodule

[tb/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the quaternion nlerp block: directed corner
// transactions, then random blends with bursty idling on both sides.
// ----------------------------------------------------------------------------
module tb;
  import qnlerp_pkg::*;

  localparam int RANDOM_ITEMS = 680;
  localparam int LATENCY      = 48;
  localparam int IDLE_LIMIT   = 5000;

  logic          clk = 1'b0;
  logic          rst_n = 1'b0;
  logic          in_valid = 1'b0;
  logic          in_ready;
  comp_t         in_src_x = '0, in_src_y = '0, in_src_z = '0, in_src_w = '0;
  comp_t         in_dest_x = '0, in_dest_y = '0, in_dest_z = '0, in_dest_w = '0;
  logic [FW-1:0] in_blend_factor = '0;
  logic          in_take_shortest = 1'b0;
  logic          out_valid;
  logic          out_ready = 1'b0;
  comp_t         out_x, out_y, out_z, out_w;
  logic          out_zero_length;
  int            fail_count;
  int            pending;

  // receiver control
  logic          hold_off = 1'b0;   // long stall requested by the sender side
  logic          calm = 1'b0;       // last part of the run, no idling
  int            idle_cycles = 0;

  always #2 clk = ~clk;

  quaternion_nlerp_normalize u_top (.*);

  nlerp_checker u_chk (.*);

  // receiver: random stall bursts, or a long hold-off
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_off) begin
      out_ready <= 1'b0;
    end else if (calm) begin
      out_ready <= 1'b1;
    end else if (idle_cycles > 0) begin
      idle_cycles <= idle_cycles - 1;
      out_ready <= 1'b0;
    end else if ($urandom_range(0, 7) == 0) begin
      idle_cycles <= $urandom_range(0, 4);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // watchdog: cycles with no transaction on either channel
  int quiet_cycles = 0;
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= IDLE_LIMIT) begin
      $display("quaternion_nlerp_normalize test failed");
      $finish;
    end
  end

  // offer one transaction and wait until it is accepted
  task automatic offer_blend(input comp_t sx, sy, sz, sw, dx, dy, dz, dw,
                             input logic [FW-1:0] fac, input logic shortest);
    in_valid <= 1'b1;
    in_src_x <= sx; in_src_y <= sy; in_src_z <= sz; in_src_w <= sw;
    in_dest_x <= dx; in_dest_y <= dy; in_dest_z <= dz; in_dest_w <= dw;
    in_blend_factor <= fac;
    in_take_shortest <= shortest;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic sender_gap();
    int n;
    n = $urandom_range(1, 5);
    in_valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  function automatic comp_t rand_comp(input int mode);
    case (mode)
      0:       return comp_t'($urandom);                        // any pattern
      1:       return comp_t'($urandom_range(0, 32768) - 16384);  // unit range
      default: return comp_t'($urandom_range(0, 2000) - 1000);    // small
    endcase
  endfunction

  task automatic random_blend();
    int    mode;
    comp_t s[4], d[4];
    logic [FW-1:0] fac;
    mode = ($urandom_range(0, 9) == 0) ? 0 : ($urandom_range(0, 5) == 0 ? 2 : 1);
    foreach (s[i]) s[i] = rand_comp(mode);
    foreach (d[i]) d[i] = rand_comp(mode);
    // occasionally make destination the negated source to reach zero length
    if ($urandom_range(0, 40) == 0) foreach (d[i]) d[i] = -s[i];
    case ($urandom_range(0, 7))
      0:       fac = FW'($urandom);
      1:       fac = FW'(ONE_Q14);
      2:       fac = '0;
      3:       fac = FW'(HALF_Q14);
      default: fac = FW'($urandom_range(0, ONE_Q14));
    endcase
    offer_blend(s[0], s[1], s[2], s[3], d[0], d[1], d[2], d[3], fac,
                1'($urandom_range(0, 1)));
  endtask

  localparam comp_t P1 = 16384;
  localparam comp_t M1 = -16384;
  localparam comp_t MN = -32768;
  localparam comp_t MX = 32767;

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // identity to identity at factor zero, identity to x at factor one and half
    offer_blend(0, 0, 0, P1, 0, 0, 0, P1, 0, 0);
    offer_blend(0, 0, 0, P1, P1, 0, 0, 0, FW'(ONE_Q14), 0);
    offer_blend(0, 0, 0, P1, P1, 0, 0, 0, FW'(HALF_Q14), 0);
    // factor above one saturates
    offer_blend(P1, 0, 0, 0, 0, P1, 0, 0, 15'h7fff, 0);
    offer_blend(P1, 0, 0, 0, 0, P1, 0, 0, 15'h4001, 1);
    // opposite quaternions: zero length without shortest, flipped with it
    offer_blend(0, 0, 0, P1, 0, 0, 0, M1, FW'(HALF_Q14), 0);
    offer_blend(0, 0, 0, P1, 0, 0, 0, M1, FW'(HALF_Q14), 1);
    // all zero inputs
    offer_blend(0, 0, 0, 0, 0, 0, 0, 0, FW'(HALF_Q14), 1);
    // dot exactly zero, not negated
    offer_blend(P1, 0, 0, 0, 0, P1, 0, 0, FW'(HALF_Q14), 1);
    // negative dot with shortest
    offer_blend(P1, P1, 0, 0, M1, 0, 0, 0, 4096, 1);
    // out-of-range patterns, most negative and most positive
    offer_blend(MN, MN, MN, MN, MX, MX, MX, MX, FW'(HALF_Q14), 0);
    offer_blend(MN, MN, MN, MN, MX, MX, MX, MX, FW'(HALF_Q14), 1);
    offer_blend(MX, MN, MX, MN, MN, MX, MN, MX, 15'h7fff, 1);
    // tiny length, output saturation corners
    offer_blend(1, 0, 0, 0, 1, 0, 0, 0, 0, 0);
    offer_blend(-1, 0, 0, 0, -1, 0, 0, 0, 0, 0);
    offer_blend(1, -1, 1, -1, -1, 1, -1, 1, FW'(HALF_Q14), 0);
    offer_blend(MX, 0, 0, 0, MX, 0, 0, 0, 1, 1);
    offer_blend(16'h5555, 16'haaaa, 16'h5555, 16'haaaa, 16'haaaa, 16'h5555,
                16'haaaa, 16'h5555, 15'h2aaa, 1);
    in_valid <= 1'b0;

    // sender pause until every expected result is back
    while (pending != 0) @(posedge clk);

    // long receiver hold-off while the sender keeps offering
    hold_off <= 1'b1;
    fork
      begin
        repeat (200) @(posedge clk);
        hold_off <= 1'b0;
      end
      begin
        for (int i = 0; i < 80; i++) random_blend();
        in_valid <= 1'b0;
      end
    join

    for (int i = 0; i < RANDOM_ITEMS - 80; i++) begin
      if (i == RANDOM_ITEMS - 180) calm <= 1'b1;
      random_blend();
      if (!calm && $urandom_range(0, 5) == 0) sender_gap();
    end
    in_valid <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
    if (fail_count == 0)
      $display("quaternion_nlerp_normalize test passed");
    else
      $display("quaternion_nlerp_normalize test failed");
    $finish;
  end

endmodule

[sim.f]
hdl/qnlerp_pkg.sv
hdl/qnlerp_blend.sv
hdl/qnlerp_sqrt.sv
hdl/qnlerp_div.sv
hdl/quaternion_nlerp_normalize.sv
tb/nlerp_checker.sv
tb/tb.sv
